>>> rtl/mbav_pkg.sv
// Shared constants, helper and transfer types for the mesh box, area and volume engine.
package mbav_pkg;

  localparam int COORD_WIDTH = 32;
  localparam int FRAC_BITS   = 16;
  localparam int COUNT_WIDTH = 24;

  function automatic int imax(input int a, input int b);
    return (a > b) ? a : b;
  endfunction

  // magnitude width of cross parts, heights, areas and box sizes
  localparam int MAG_W  = imax(2 * COORD_WIDTH + 1 - FRAC_BITS, COORD_WIDTH);
  localparam int PROD_W = 2 * MAG_W + 2;
  localparam int ACC_W  = imax(PROD_W, 2 * COORD_WIDTH + 3) + 1;
  localparam int Q_W    = imax(PROD_W, FRAC_BITS + 65);

  localparam logic [62:0] MAX63 = '1;

  typedef struct packed {
    logic signed [31:0] coord_x;
    logic signed [31:0] coord_y;
    logic signed [31:0] coord_z;
    logic               last_facet;
  } mbav_in_t;

  typedef struct packed {
    logic signed [31:0] min_x;
    logic signed [31:0] min_y;
    logic signed [31:0] min_z;
    logic signed [31:0] max_x;
    logic signed [31:0] max_y;
    logic signed [31:0] max_z;
    logic [62:0]        surface_area;
    logic [62:0]        enclosed_volume;
    logic [32:0]        box_diagonal;
    logic [23:0]        facet_total;
  } mbav_out_t;

endpackage

>>> rtl/mesh_bbox_area_volume_top.sv
// Mesh bounding box, surface area and volume engine around one shared shift-add multiplier.
//
//   channel | ports                          | payload
//   input   | in_valid, in_stall, in_data    | normal or vertex, last_facet flag
//   output  | out_valid, out_stall, out_data | box, area, volume, diagonal, facets
//
// Normal, v0 and v1 are each taken while idle. The third vertex holds in_stall
// while the facet runs on the bit-serial multiplier and square root, plus a
// seven-step shift-add divide by three; the last facet then also squares the
// box sizes and takes the root for the diagonal.
// in_stall is high while a facet is being worked on. A result waits in the
// output register under out_stall; the engine holds before loading a new one.
// Synchronous active-low reset; no clearing pass.
module mesh_bbox_area_volume_top (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  mbav_pkg::mbav_in_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output mbav_pkg::mbav_out_t out_data
);

  localparam int CW    = mbav_pkg::COORD_WIDTH;
  localparam int F     = mbav_pkg::FRAC_BITS;
  localparam int NW    = mbav_pkg::COUNT_WIDTH;
  localparam int MW    = mbav_pkg::MAG_W;
  localparam int SW    = MW + 1;
  localparam int PW    = mbav_pkg::PROD_W;
  localparam int AW    = mbav_pkg::ACC_W;
  localparam int QW    = mbav_pkg::Q_W;
  localparam int CNT_W = $clog2(mbav_pkg::imax(64, mbav_pkg::imax(MW, PW / 2)) + 1);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_DISP = 3'd1;
  localparam logic [2:0] ST_MUL  = 3'd2;
  localparam logic [2:0] ST_ACC  = 3'd3;
  localparam logic [2:0] ST_SQRT = 3'd4;
  localparam logic [2:0] ST_DIV  = 3'd5;
  localparam logic [2:0] ST_OUT  = 3'd6;

  localparam logic [2:0] K_MUL = 3'd0;
  localparam logic [2:0] K_CST = 3'd1;
  localparam logic [2:0] K_SQA = 3'd2;
  localparam logic [2:0] K_HGT = 3'd3;
  localparam logic [2:0] K_DIV = 3'd4;
  localparam logic [2:0] K_VOL = 3'd5;
  localparam logic [2:0] K_SQD = 3'd6;

  localparam logic [4:0] PC_CROSS1    = 5'd5;
  localparam logic [4:0] PC_AREA_SQRT = 5'd12;
  localparam logic [4:0] PC_DIAG_MUL  = 5'd20;
  localparam logic [4:0] PC_LAST      = 5'd23;

  localparam logic [1:0] SLOT_NORMAL = 2'd0;
  localparam logic [1:0] SLOT_V0     = 2'd1;
  localparam logic [1:0] SLOT_V1     = 2'd2;
  localparam logic [1:0] SLOT_V2     = 2'd3;

  logic [2:0]              st_r;
  logic [4:0]              pc_r;
  logic [1:0]              slot_r;
  logic                    first_r;
  logic                    last_r;
  logic signed [CW-1:0]    nrm_r  [3];
  logic signed [CW-1:0]    v0_r   [3];
  logic signed [CW-1:0]    v1_r   [3];
  logic signed [CW-1:0]    v2_r   [3];
  logic signed [CW-1:0]    ref_r  [3];
  logic signed [CW-1:0]    bmin_r [3];
  logic signed [CW-1:0]    bmax_r [3];
  logic [62:0]             asum_r;
  logic signed [63:0]      vsum_r;
  logic [NW-1:0]           fcnt_r;
  logic [MW-1:0]           c_r    [3];
  logic [MW-1:0]           area_r;
  logic [MW-1:0]           h_r;
  logic                    hneg_r;
  logic [PW-1:0]           ma_r;
  logic [MW-1:0]           mb_r;
  logic [PW-1:0]           prod_r;
  logic                    mneg_r;
  logic [CNT_W-1:0]        cnt_r;
  logic signed [AW-1:0]    acc_r;
  logic [PW-1:0]           sop_r;
  logic [PW-1:0]           sres_r;
  logic [PW-1:0]           sone_r;
  logic [63:0]             dq_r;
  logic [63:0]             dn_r;
  logic [4:0]              dr_r;
  logic [62:0]             tmag_r;
  logic [32:0]             diag_r;
  logic                    out_valid_r;
  mbav_pkg::mbav_out_t     out_r;

  logic signed [CW-1:0]    vin [3];
  logic signed [CW:0]      da [3];
  logic signed [CW:0]      db [3];
  logic signed [CW:0]      de [3];
  logic signed [CW:0]      dg [3];
  logic [2:0]              kind;
  logic signed [SW-1:0]    opx;
  logic signed [SW-1:0]    opy;
  logic                    opsub;
  logic [MW-1:0]           xm;
  logic [MW-1:0]           ym;
  logic signed [AW-1:0]    pe;
  logic [AW-1:0]           accm;
  logic [MW-1:0]           accsh;
  logic [1:0]              cidx;
  logic [PW-1:0]           ssum;
  logic                    sge;
  logic [PW-1:0]           sres_n;
  logic [QW-1:0]           qx;
  logic [8:0]              d11;
  logic [3:0]              dcor;
  logic [62:0]             area_n;
  logic [62:0]             vmag;
  logic signed [63:0]      tms;
  logic signed [63:0]      vsum_n;
  logic                    accept;
  logic                    out_load;

  assign vin[0] = in_data.coord_x[CW-1:0];
  assign vin[1] = in_data.coord_y[CW-1:0];
  assign vin[2] = in_data.coord_z[CW-1:0];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      da[i] = (CW + 1)'(v1_r[i]) - (CW + 1)'(v0_r[i]);
      db[i] = (CW + 1)'(v2_r[i]) - (CW + 1)'(v0_r[i]);
      de[i] = (CW + 1)'(v0_r[i]) - (CW + 1)'(ref_r[i]);
      dg[i] = (CW + 1)'(bmax_r[i]) - (CW + 1)'(bmin_r[i]);
    end
  end

  always_comb begin
    case (pc_r) inside
      5'd2, 5'd5, 5'd8: kind = K_CST;
      5'd12:            kind = K_SQA;
      5'd16:            kind = K_HGT;
      5'd18:            kind = K_DIV;
      5'd19:            kind = K_VOL;
      5'd23:            kind = K_SQD;
      default:          kind = K_MUL;
    endcase
  end

  always_comb begin
    opsub = 1'b0;
    case (pc_r)
      5'd0:  begin opx = SW'(da[1]); opy = SW'(db[2]); end
      5'd1:  begin opx = SW'(da[2]); opy = SW'(db[1]); opsub = 1'b1; end
      5'd3:  begin opx = SW'(da[2]); opy = SW'(db[0]); end
      5'd4:  begin opx = SW'(da[0]); opy = SW'(db[2]); opsub = 1'b1; end
      5'd6:  begin opx = SW'(da[0]); opy = SW'(db[1]); end
      5'd7:  begin opx = SW'(da[1]); opy = SW'(db[0]); opsub = 1'b1; end
      5'd9:  begin opx = $signed({1'b0, c_r[0]}); opy = $signed({1'b0, c_r[0]}); end
      5'd10: begin opx = $signed({1'b0, c_r[1]}); opy = $signed({1'b0, c_r[1]}); end
      5'd11: begin opx = $signed({1'b0, c_r[2]}); opy = $signed({1'b0, c_r[2]}); end
      5'd13: begin opx = SW'(nrm_r[0]); opy = SW'(de[0]); end
      5'd14: begin opx = SW'(nrm_r[1]); opy = SW'(de[1]); end
      5'd15: begin opx = SW'(nrm_r[2]); opy = SW'(de[2]); end
      5'd17: begin opx = $signed({1'b0, area_r}); opy = $signed({1'b0, h_r}); end
      5'd20: begin opx = SW'(dg[0]); opy = SW'(dg[0]); end
      5'd21: begin opx = SW'(dg[1]); opy = SW'(dg[1]); end
      5'd22: begin opx = SW'(dg[2]); opy = SW'(dg[2]); end
      default: begin opx = '0; opy = '0; end
    endcase
  end

  assign xm = opx[SW-1] ? MW'(-opx) : MW'(opx);
  assign ym = opy[SW-1] ? MW'(-opy) : MW'(opy);

  assign pe    = $signed(AW'(prod_r));
  assign accm  = acc_r[AW-1] ? AW'(-acc_r) : AW'(acc_r);
  assign accsh = MW'(accm >> F);
  assign cidx  = (pc_r == 5'd2) ? 2'd0 : ((pc_r == PC_CROSS1) ? 2'd1 : 2'd2);

  assign ssum   = sres_r + sone_r;
  assign sge    = (sop_r >= ssum);
  assign sres_n = sge ? ((sres_r >> 1) + sone_r) : (sres_r >> 1);

  // divide by three: series estimate, then a small remainder correction
  assign qx   = QW'(acc_r[PW-1:0]);
  assign d11  = {1'b0, dr_r, 3'b000} + {3'b000, dr_r, 1'b0} + {4'b0000, dr_r};
  assign dcor = d11[8:5];

  assign area_n = 63'(sres_n >> 1);
  assign vmag   = vsum_r[63] ? 63'(-vsum_r) : vsum_r[62:0];
  assign tms    = $signed({1'b0, tmag_r});

  always_comb begin
    if (!hneg_r) begin
      if (!vsum_r[63] && (vsum_r != 64'sd0) && (tmag_r > (mbav_pkg::MAX63 - vsum_r[62:0])))
        vsum_n = $signed({1'b0, mbav_pkg::MAX63});
      else
        vsum_n = vsum_r + tms;
    end else begin
      if (vsum_r[63] && (tmag_r > (mbav_pkg::MAX63 - vmag)))
        vsum_n = -$signed({1'b0, mbav_pkg::MAX63});
      else
        vsum_n = vsum_r - tms;
    end
  end

  assign in_stall = (st_r != ST_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_load = (st_r == ST_OUT) && (!out_valid_r || !out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      pc_r        <= '0;
      slot_r      <= SLOT_NORMAL;
      first_r     <= 1'b1;
      asum_r      <= '0;
      vsum_r      <= '0;
      fcnt_r      <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        nrm_r[i]  <= '0;
        v0_r[i]   <= '0;
        v1_r[i]   <= '0;
        ref_r[i]  <= '0;
        bmin_r[i] <= '0;
        bmax_r[i] <= '0;
      end
    end else begin
      if (out_load)
        out_valid_r <= 1'b1;
      else if (!out_stall)
        out_valid_r <= 1'b0;

      case (st_r)
        ST_IDLE: begin
          if (accept) begin
            if (slot_r == SLOT_NORMAL) begin
              for (int i = 0; i < 3; i++) nrm_r[i] <= vin[i];
            end else begin
              for (int i = 0; i < 3; i++) begin
                if (first_r) begin
                  ref_r[i]  <= vin[i];
                  bmin_r[i] <= vin[i];
                  bmax_r[i] <= vin[i];
                end else begin
                  if (vin[i] < bmin_r[i]) bmin_r[i] <= vin[i];
                  if (vin[i] > bmax_r[i]) bmax_r[i] <= vin[i];
                end
              end
              first_r <= 1'b0;
            end
            if (slot_r == SLOT_V0) begin
              for (int i = 0; i < 3; i++) v0_r[i] <= vin[i];
            end
            if (slot_r == SLOT_V1) begin
              for (int i = 0; i < 3; i++) v1_r[i] <= vin[i];
            end
            if (slot_r == SLOT_V2) begin
              for (int i = 0; i < 3; i++) v2_r[i] <= vin[i];
              last_r <= in_data.last_facet;
              acc_r  <= '0;
              pc_r   <= '0;
              st_r   <= ST_DISP;
            end
            slot_r <= slot_r + 2'd1;
          end
        end

        ST_DISP: begin
          case (kind)
            K_MUL: begin
              ma_r   <= PW'(xm);
              mb_r   <= ym;
              mneg_r <= opx[SW-1] ^ opy[SW-1] ^ opsub;
              prod_r <= '0;
              cnt_r  <= CNT_W'(MW);
              st_r   <= ST_MUL;
            end
            K_CST: begin
              c_r[cidx] <= accsh;
              acc_r     <= '0;
              pc_r      <= pc_r + 5'd1;
            end
            K_SQA, K_SQD: begin
              sop_r  <= PW'(acc_r);
              sres_r <= '0;
              sone_r <= PW'(1) << (PW - 2);
              cnt_r  <= CNT_W'(PW / 2);
              st_r   <= ST_SQRT;
            end
            K_HGT: begin
              h_r    <= accsh;
              hneg_r <= acc_r[AW-1];
              acc_r  <= '0;
              pc_r   <= pc_r + 5'd1;
            end
            K_DIV: begin
              if (|qx[QW-1:F+64]) begin
                tmag_r <= mbav_pkg::MAX63;
                pc_r   <= pc_r + 5'd1;
              end else begin
                dn_r  <= qx[F+63:F];
                cnt_r <= CNT_W'(7);
                st_r  <= ST_DIV;
              end
            end
            K_VOL: begin
              vsum_r <= vsum_n;
              if (fcnt_r != '1) fcnt_r <= fcnt_r + NW'(1);
              acc_r <= '0;
              if (last_r) begin
                pc_r <= PC_DIAG_MUL;
              end else begin
                st_r <= ST_IDLE;
              end
            end
            default: st_r <= ST_IDLE;
          endcase
        end

        ST_MUL: begin
          if (mb_r[0]) prod_r <= prod_r + ma_r;
          ma_r  <= ma_r << 1;
          mb_r  <= mb_r >> 1;
          cnt_r <= cnt_r - CNT_W'(1);
          if (cnt_r == CNT_W'(1)) st_r <= ST_ACC;
        end

        ST_ACC: begin
          acc_r <= mneg_r ? (acc_r - pe) : (acc_r + pe);
          pc_r  <= pc_r + 5'd1;
          st_r  <= ST_DISP;
        end

        ST_SQRT: begin
          if (sge) sop_r <= sop_r - ssum;
          sres_r <= sres_n;
          sone_r <= sone_r >> 2;
          cnt_r  <= cnt_r - CNT_W'(1);
          if (cnt_r == CNT_W'(1)) begin
            if (pc_r == PC_AREA_SQRT) begin
              area_r <= MW'(area_n);
              asum_r <= (area_n > (mbav_pkg::MAX63 - asum_r)) ? mbav_pkg::MAX63
                                                                : asum_r + area_n;
              acc_r  <= '0;
              pc_r   <= pc_r + 5'd1;
              st_r   <= ST_DISP;
            end else begin
              diag_r <= 33'(sres_n);
              st_r   <= ST_OUT;
            end
          end
        end

        ST_DIV: begin
          cnt_r <= cnt_r - CNT_W'(1);
          case (cnt_r)
            CNT_W'(7): dq_r <= (dn_r >> 2) + (dn_r >> 4);
            CNT_W'(6): dq_r <= dq_r + (dq_r >> 4);
            CNT_W'(5): dq_r <= dq_r + (dq_r >> 8);
            CNT_W'(4): dq_r <= dq_r + (dq_r >> 16);
            CNT_W'(3): dq_r <= dq_r + (dq_r >> 32);
            // estimate is short by under six, so the remainder fits five bits
            CNT_W'(2): dr_r <= dn_r[4:0] - dq_r[4:0] - {dq_r[3:0], 1'b0};
            default: begin
              tmag_r <= 63'(dq_r + 64'(dcor));
              pc_r   <= pc_r + 5'd1;
              st_r   <= ST_DISP;
            end
          endcase
        end

        ST_OUT: begin
          if (out_load) begin
            out_r.min_x           <= 32'(bmin_r[0]);
            out_r.min_y           <= 32'(bmin_r[1]);
            out_r.min_z           <= 32'(bmin_r[2]);
            out_r.max_x           <= 32'(bmax_r[0]);
            out_r.max_y           <= 32'(bmax_r[1]);
            out_r.max_z           <= 32'(bmax_r[2]);
            out_r.surface_area    <= asum_r;
            out_r.enclosed_volume <= vmag;
            out_r.box_diagonal    <= diag_r;
            out_r.facet_total     <= 24'(fcnt_r);
            first_r <= 1'b1;
            asum_r  <= '0;
            vsum_r  <= '0;
            fcnt_r  <= '0;
            for (int i = 0; i < 3; i++) begin
              nrm_r[i]  <= '0;
              v0_r[i]   <= '0;
              v1_r[i]   <= '0;
              ref_r[i]  <= '0;
              bmin_r[i] <= '0;
              bmax_r[i] <= '0;
            end
            st_r <= ST_IDLE;
          end
        end

        default: st_r <= ST_IDLE;
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

`ifndef SYNTHESIS
  a_out_from_seq: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(st_r) == ST_OUT)
    else $error("result transfer raised outside output step");

  a_vsum_sym: assert property (@(posedge clk) disable iff (!rst_n)
    vsum_r != {1'b1, 63'b0})
    else $error("volume sum left its symmetric range");

  a_v2_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && slot_r == SLOT_V2) |=> st_r == ST_DISP && pc_r == 5'd0)
    else $error("third vertex did not start the facet sequence");

  a_pc_range: assert property (@(posedge clk) disable iff (!rst_n)
    pc_r <= PC_LAST)
    else $error("step counter out of range");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |=> $stable(out_r))
    else $error("held result overwritten");
`endif

endmodule
